@@ design/ctt_pkg.sv @@
`default_nettype none

package ctt_pkg;

  // Default slot count and per-scan report limit.
  localparam int NUM_SLOTS_DEF = 32;
  localparam int MAX_RESULTS   = 32;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam int TIME_W    = 32;
  localparam int PHASE_W   = 3;
  localparam int REQ_W     = 3;
  localparam int SLOT_W    = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER   = 3'd0,
    REQ_TOUCH      = 3'd1,
    REQ_SET_PHASE  = 3'd2,
    REQ_UNREGISTER = 3'd3,
    REQ_SCAN       = 3'd4
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT   = 3'd0,
    REG_HEADER_TIMEOUT = 3'd1,
    REG_BODY_TIMEOUT   = 3'd2,
    REG_WRITE_TIMEOUT  = 3'd3
  } cfg_reg_e;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BODY    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WRITING = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [SLOT_W-1:0]  slot_index;
    logic [PHASE_W-1:0] new_phase;
    logic [TIME_W-1:0]  now_ms;
  } in_word_t;

  typedef struct packed {
    logic              close_valid;
    logic [SLOT_W-1:0] close_slot;
    logic              last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ev_register;
    logic ev_touch;
    logic ev_setph;
    logic ev_unreg;
    logic ph_check;
    logic scan_start;
    logic scan_sel;
    logic scan_step;
    logic scan_finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ev_ok;
    logic hit;
    logic held_valid;
    logic out_free;
    logic walk_done;
  } sts_t;

endpackage

`default_nettype wire

@@ design/ctt_ram.sv @@
`default_nettype none

module ctt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ design/ctt_ctrl.sv @@
`default_nettype none

module ctt_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ctt_pkg::REQ_W-1:0]   req_type,
  input  wire ctt_pkg::sts_t               sts,
  output ctt_pkg::cmd_t                    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PH   = 5'b00010,
    ST_RD   = 5'b00100,
    ST_EV   = 5'b01000,
    ST_END  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            ctt_pkg::REQ_REGISTER: begin
              cmd.ev_register = 1'b1;
            end
            ctt_pkg::REQ_TOUCH: begin
              cmd.ev_touch = 1'b1;
            end
            ctt_pkg::REQ_SET_PHASE: begin
              cmd.ev_setph = 1'b1;
              if (sts.ev_ok) begin
                state_nxt = ST_PH;
              end
            end
            ctt_pkg::REQ_UNREGISTER: begin
              cmd.ev_unreg = 1'b1;
            end
            ctt_pkg::REQ_SCAN: begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PH: begin
        cmd.ph_check = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_RD: begin
        cmd.scan_sel = 1'b1;
        state_nxt    = ST_EV;
      end
      ST_EV: begin
        cmd.scan_sel = 1'b1;
        // A hit with a report already held must hand that report on first.
        if (!(sts.hit && sts.held_valid && !sts.out_free)) begin
          cmd.scan_step = 1'b1;
          state_nxt     = sts.walk_done ? ST_END : ST_RD;
        end
      end
      ST_END: begin
        if (sts.out_free) begin
          cmd.scan_finish = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/ctt_datapath.sv @@
`default_nettype none

module ctt_datapath #(
  parameter int NUM_SLOTS = ctt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ctt_pkg::in_word_t                 in_data,
  input  wire ctt_pkg::cmd_t                     cmd,
  output ctt_pkg::sts_t                          sts,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ctt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ctt_pkg::TIME_W-1:0]        cfg_data,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output ctt_pkg::out_word_t                     out_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW    = ctt_pkg::TIME_W;
  localparam int PW    = ctt_pkg::PHASE_W;
  localparam int CW    = ctt_pkg::CNT_W;

  logic [TW-1:0]        idle_lim_r, idle_lim_nxt;
  logic [TW-1:0]        hdr_lim_r, hdr_lim_nxt;
  logic [TW-1:0]        body_lim_r, body_lim_nxt;
  logic [TW-1:0]        wr_lim_r, wr_lim_nxt;
  logic [TW-1:0]        cur_time_r, cur_time_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 held_valid_r, held_valid_nxt;
  logic [IDX_W-1:0]     held_slot_r, held_slot_nxt;
  logic [IDX_W-1:0]     ev_addr_r, ev_addr_nxt;
  logic [PW-1:0]        new_phase_r, new_phase_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ctt_pkg::out_word_t   out_data_r, out_data_nxt;

  logic [IDX_W-1:0]     ev_addr;
  logic                 in_range;
  logic                 ev_valid;
  logic [IDX_W-1:0]     rd_addr;
  logic                 ps_we;
  logic [IDX_W-1:0]     ps_addr;
  logic [PW-1:0]        ph_wdata;
  logic                 la_we;
  logic [PW-1:0]        rd_phase;
  logic [TW-1:0]        rd_start;
  logic [TW-1:0]        rd_last;
  logic [TW-1:0]        ph_lim;
  logic [TW-1:0]        idle_elapsed;
  logic [TW-1:0]        ph_elapsed;
  logic                 hit;

  assign ev_addr  = IDX_W'(in_data.slot_index);
  assign in_range = {2'b00, in_data.slot_index} < 7'(NUM_SLOTS);
  assign ev_valid = in_range && valid_r[ev_addr];
  assign rd_addr  = cmd.scan_sel ? idx_r : ev_addr;

  // Phase and phase-start time share one memory; last-activity time has its own.
  assign ps_we    = (cmd.ev_register && in_range) ||
                    (cmd.ph_check && (rd_phase != new_phase_r));
  assign ps_addr  = cmd.ph_check ? ev_addr_r : ev_addr;
  assign ph_wdata = cmd.ph_check ? new_phase_r : ctt_pkg::PH_IDLE;
  assign la_we    = (cmd.ev_register && in_range) ||
                    ((cmd.ev_touch || cmd.ev_setph) && ev_valid);

  ctt_ram #(.WIDTH(PW + TW), .DEPTH(NUM_SLOTS)) u_ps_ram (
    .clk     (clk),
    .wr_en   (ps_we),
    .wr_addr (ps_addr),
    .wr_data ({ph_wdata, cur_time_r}),
    .rd_addr (rd_addr),
    .rd_data ({rd_phase, rd_start})
  );

  ctt_ram #(.WIDTH(TW), .DEPTH(NUM_SLOTS)) u_la_ram (
    .clk     (clk),
    .wr_en   (la_we),
    .wr_addr (ev_addr),
    .wr_data (cur_time_r),
    .rd_addr (rd_addr),
    .rd_data (rd_last)
  );

  always_comb begin
    case (rd_phase)
      ctt_pkg::PH_HEADER:  ph_lim = hdr_lim_r;
      ctt_pkg::PH_BODY:    ph_lim = body_lim_r;
      ctt_pkg::PH_WRITING: ph_lim = wr_lim_r;
      default:             ph_lim = '0;
    endcase
  end

  // Elapsed times wrap modulo 2^32, as the subtraction does naturally.
  assign idle_elapsed = cur_time_r - rd_last;
  assign ph_elapsed   = cur_time_r - rd_start;
  assign hit = valid_r[idx_r] &&
               (((idle_lim_r != '0) && (idle_elapsed >= idle_lim_r)) ||
                ((ph_lim != '0) && (ph_elapsed >= ph_lim)));

  assign sts.ev_ok      = ev_valid;
  assign sts.hit        = hit;
  assign sts.held_valid = held_valid_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.walk_done  = (idx_r == IDX_W'(NUM_SLOTS - 1)) ||
                          (hit && (cnt_r == CW'(ctt_pkg::MAX_RESULTS - 1)));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    idle_lim_nxt   = idle_lim_r;
    hdr_lim_nxt    = hdr_lim_r;
    body_lim_nxt   = body_lim_r;
    wr_lim_nxt     = wr_lim_r;
    cur_time_nxt   = cur_time_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    held_valid_nxt = held_valid_r;
    held_slot_nxt  = held_slot_r;
    ev_addr_nxt    = ev_addr_r;
    new_phase_nxt  = new_phase_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        ctt_pkg::REG_IDLE_TIMEOUT:   idle_lim_nxt = cfg_data;
        ctt_pkg::REG_HEADER_TIMEOUT: hdr_lim_nxt  = cfg_data;
        ctt_pkg::REG_BODY_TIMEOUT:   body_lim_nxt = cfg_data;
        ctt_pkg::REG_WRITE_TIMEOUT:  wr_lim_nxt   = cfg_data;
        default: begin
        end
      endcase
    end

    if (cmd.ev_register && in_range) begin
      valid_nxt[ev_addr] = 1'b1;
    end
    if (cmd.ev_unreg && in_range) begin
      valid_nxt[ev_addr] = 1'b0;
    end
    if (cmd.ev_setph) begin
      ev_addr_nxt   = ev_addr;
      new_phase_nxt = in_data.new_phase;
    end

    if (cmd.scan_start) begin
      cur_time_nxt   = in_data.now_ms;
      idx_nxt        = '0;
      cnt_nxt        = '0;
      held_valid_nxt = 1'b0;
    end

    // The newest hit is held back so that the final report can carry last.
    if (cmd.scan_step) begin
      idx_nxt = idx_r + 1'b1;
      if (hit) begin
        if (held_valid_r) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.close_valid = 1'b1;
          out_data_nxt.close_slot  = ctt_pkg::SLOT_W'(held_slot_r);
          out_data_nxt.last        = 1'b0;
        end
        held_valid_nxt = 1'b1;
        held_slot_nxt  = idx_r;
        cnt_nxt        = cnt_r + 1'b1;
      end
    end

    if (cmd.scan_finish) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.close_valid = held_valid_r;
      out_data_nxt.close_slot  = held_valid_r ? ctt_pkg::SLOT_W'(held_slot_r) : '0;
      out_data_nxt.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_lim_r   <= '0;
      hdr_lim_r    <= '0;
      body_lim_r   <= '0;
      wr_lim_r     <= '0;
      cur_time_r   <= '0;
      valid_r      <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      idle_lim_r   <= idle_lim_nxt;
      hdr_lim_r    <= hdr_lim_nxt;
      body_lim_r   <= body_lim_nxt;
      wr_lim_r     <= wr_lim_nxt;
      cur_time_r   <= cur_time_nxt;
      valid_r      <= valid_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_slot_r <= held_slot_nxt;
    ev_addr_r   <= ev_addr_nxt;
    new_phase_r <= new_phase_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ design/connection_timeout_table.sv @@
// Register, touch and unregister words finish in the accepting cycle; set phase on a valid slot adds a
// phase check state. Scan tick: the time is latched, then each slot passes through a read state and a
// check state until the last slot or the report limit; then the final word goes out once the output is free.
// Throughput is one word at a time, bounded by the single read port of the slot memories.
// Reset (synchronous, rst_n low) clears the valid bits, the timeout registers and the current time;
// slot memory contents are not cleared, so no clearing pass runs and the block is ready at once.
`default_nettype none

module connection_timeout_table #(
  parameter int NUM_SLOTS = ctt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Event channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire ctt_pkg::in_word_t                 in_data,
  // Close report channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output ctt_pkg::out_word_t                     out_data,
  // Timeout register writes.
  input  wire logic                              cfg_wr_en,
  input  wire logic [ctt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ctt_pkg::TIME_W-1:0]        cfg_data
);

  // The controller sequences events and the slot walk; the datapath owns the
  // slot memories, valid bits, timeout registers and the output register.
  // They talk only through the command and status structs below.
  ctt_pkg::cmd_t cmd;
  ctt_pkg::sts_t sts;

  // The controller takes a new word only when idle. Non-scan words finish in
  // the accepting cycle, apart from set phase on a valid slot, which moves to a
  // phase check state to compare the stored phase read from memory before rewriting it.
  ctt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (in_data.req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  // During a scan, each slot is read and then checked against the idle limit
  // and its phase limit. The most recent hit is held back so that the
  // last flag can be set on the final report of the walk; earlier hits go out
  // through the output register, and the walk waits while that register is
  // full. The walk ends at the last slot or after the per-scan report limit.
  ctt_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
